### hw/rtl/msawc_pkg.sv
// ---------------------------------------------------------------------------
// msawc_pkg: shared types and constants
// Field widths, register indexes and the controller/datapath handshake types.
// ---------------------------------------------------------------------------
package msawc_pkg;

    localparam int DIST_W     = 12;
    localparam int LEN_W      = 12;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 8;
    // threshold is 12.4, so T*T carries 8 fraction bits
    localparam int THR_SQ_FRAC = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_LENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_LENGTH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_IS_OPEN   = 2'd3;

    // one-hot step commands from the controller
    typedef struct packed {
        logic capture;  // latch the request
        logic read;     // read the slot about to be overwritten
        logic square;   // square old and new sample
        logic accum;    // update ring, sums, count and slot
        logic mul;      // form the four products
        logic diff;     // form lhs and rhs of the spread test
        logic finish;   // load the result register
    } t_cmd;

    typedef struct packed {
        logic out_valid;
    } t_sts;

endpackage

### hw/rtl/msawc_ctl.sv
// ---------------------------------------------------------------------------
// msawc_ctl: step sequencer
// Walks one request through the datapath steps and hands off the result.
// ---------------------------------------------------------------------------
module msawc_ctl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic              i_m_tready,
    input  msawc_pkg::t_sts   i_sts,
    output msawc_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DIFF = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_finish;

    assign o_s_tready = (r_state == S_IDLE);
    // load the result once the output register is free or being drained
    assign w_finish   = (r_state == S_DONE) && (!i_sts.out_valid || i_m_tready);

    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = o_s_tready && i_s_tvalid;
        o_cmd.read    = (r_state == S_READ);
        o_cmd.square  = (r_state == S_SQ);
        o_cmd.accum   = (r_state == S_ACC);
        o_cmd.mul     = (r_state == S_MUL);
        o_cmd.diff    = (r_state == S_DIFF);
        o_cmd.finish  = w_finish;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_s_tvalid) n_state = S_READ;
            S_READ: n_state = S_SQ;
            S_SQ:   n_state = S_ACC;
            S_ACC:  n_state = S_MUL;
            S_MUL:  n_state = S_DIFF;
            S_DIFF: n_state = S_DONE;
            S_DONE: if (w_finish) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/msawc_dp.sv
// ---------------------------------------------------------------------------
// msawc_dp: window datapath
// Sample ring, running sums, spread products, config and result registers.
// ---------------------------------------------------------------------------
module msawc_dp #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [msawc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [msawc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [msawc_pkg::S_DATA_W-1:0]       i_s_tdata,
    input  logic                                 i_m_tready,
    output logic                                 o_m_tvalid,
    output logic [msawc_pkg::M_DATA_W-1:0]       o_m_tdata,
    input  msawc_pkg::t_cmd                      i_cmd,
    output msawc_pkg::t_sts                      o_sts
);

    localparam int DW     = msawc_pkg::DIST_W;
    localparam int LW     = msawc_pkg::LEN_W;
    localparam int TW     = msawc_pkg::THR_W;
    localparam int FR     = msawc_pkg::THR_SQ_FRAC;
    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = DW + SLOT_W;
    localparam int SQ_W   = 2 * DW + SLOT_W;
    localparam int P1_W   = CNT_W + SQ_W;
    localparam int P2_W   = 2 * SUM_W;
    localparam int P3_W   = 2 * TW;
    localparam int P4_W   = 2 * CNT_W;
    localparam int RHS_W  = P3_W + P4_W;
    localparam int CMP_W  = ((P1_W + FR) > RHS_W) ? (P1_W + FR) : RHS_W;

    // configuration
    logic [LW-1:0]      r_close_len;
    logic [LW-1:0]      r_open_len;
    logic [TW-1:0]      r_thr;
    logic               r_is_open;

    // window state
    logic [DW-1:0]      r_ring [WINDOW_DEPTH];
    logic [CNT_W-1:0]   r_cnt;
    logic [SLOT_W-1:0]  r_slot;
    logic [SUM_W-1:0]   r_sum;
    logic [SQ_W-1:0]    r_sumsq;
    logic               r_prev_motion;
    logic               r_out_valid;

    // per-request payload
    logic               r_motion;
    logic [DW-1:0]      r_dist;
    logic [DW-1:0]      r_old;
    logic [2*DW-1:0]    r_old_sq;
    logic [2*DW-1:0]    r_dist_sq;
    logic [P1_W-1:0]    r_p1;
    logic [P2_W-1:0]    r_p2;
    logic [P3_W-1:0]    r_p3;
    logic [P4_W-1:0]    r_p4;
    logic [P1_W-1:0]    r_lhs;
    logic [RHS_W-1:0]   r_rhs;
    logic [msawc_pkg::M_DATA_W-1:0] r_out;

    logic               w_full;
    logic [DW-1:0]      w_old;
    logic [2*DW-1:0]    w_old_sq;
    logic               w_move;
    logic               w_ccw;
    logic               w_buzz;
    logic               w_spread;

    assign w_full   = (r_cnt == CNT_W'(WINDOW_DEPTH));
    assign w_old    = w_full ? r_old : '0;
    assign w_old_sq = w_full ? r_old_sq : '0;

    assign w_move   = r_is_open ? (r_dist > r_open_len) : (r_dist > r_close_len);
    assign w_ccw    = r_is_open && (r_dist > r_open_len);
    assign w_spread = CMP_W'({r_lhs, FR'(0)}) > CMP_W'(r_rhs);
    assign w_buzz   = !r_prev_motion && r_motion && (r_cnt >= CNT_W'(2)) && w_spread;

    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = r_out;
    assign o_sts.out_valid = r_out_valid;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_close_len   <= '0;
            r_open_len    <= '0;
            r_thr         <= '0;
            r_is_open     <= 1'b0;
            r_cnt         <= '0;
            r_slot        <= '0;
            r_sum         <= '0;
            r_sumsq       <= '0;
            r_prev_motion <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    msawc_pkg::REG_CLOSE_LENGTH:     r_close_len <= i_cfg_data[LW-1:0];
                    msawc_pkg::REG_OPEN_LENGTH:      r_open_len  <= i_cfg_data[LW-1:0];
                    msawc_pkg::REG_SPREAD_THRESHOLD: r_thr       <= i_cfg_data[TW-1:0];
                    msawc_pkg::REG_WINDOW_IS_OPEN:   r_is_open   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.accum) begin
                r_sum   <= r_sum - SUM_W'(w_old) + SUM_W'(r_dist);
                r_sumsq <= r_sumsq - SQ_W'(w_old_sq) + SQ_W'(r_dist_sq);
                if (!w_full) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                if (r_slot == SLOT_W'(WINDOW_DEPTH - 1)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + SLOT_W'(1);
                end
            end
            if (i_cmd.finish) begin
                r_prev_motion <= r_motion;
                r_out_valid   <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    // ring storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.accum) begin
            r_ring[r_slot] <= r_dist;
        end
        if (i_cmd.read) begin
            r_old <= r_ring[r_slot];
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_motion <= i_s_tdata[0];
            r_dist   <= i_s_tdata[DW:1];
        end
        if (i_cmd.square) begin
            r_old_sq  <= (2*DW)'(r_old) * (2*DW)'(r_old);
            r_dist_sq <= (2*DW)'(r_dist) * (2*DW)'(r_dist);
        end
        if (i_cmd.mul) begin
            r_p1 <= P1_W'(r_cnt) * P1_W'(r_sumsq);
            r_p2 <= P2_W'(r_sum) * P2_W'(r_sum);
            r_p3 <= P3_W'(r_thr) * P3_W'(r_thr);
            r_p4 <= P4_W'(r_cnt) * P4_W'(r_cnt - CNT_W'(1));
        end
        if (i_cmd.diff) begin
            r_lhs <= r_p1 - P1_W'(r_p2);
            r_rhs <= RHS_W'(r_p3) * RHS_W'(r_p4);
        end
        if (i_cmd.finish) begin
            r_out <= {5'b0, w_buzz, w_ccw, w_move};
        end
    end

endmodule

### hw/rtl/motion_spread_alarm_window_ctl_unit.sv
// ---------------------------------------------------------------------------
// motion_spread_alarm_window_ctl_unit: motion spread alarm and window control
// Sliding-window distance spread test on motion edges plus window motor flags.
// ---------------------------------------------------------------------------
// Each accepted sensor tick (motion level, distance) produces exactly one
// result (window_move, window_ccw, buzzer). The distance joins a ring of the
// last WINDOW_DEPTH samples with running sum and sum of squares; on a rising
// motion edge the buzzer is set when n*sumsq - sum^2, scaled by 256, exceeds
// T^2*n*(n-1), T being the 12.4 threshold; fewer than two samples never alarm.
// A tick goes from acceptance to the result register through these steps: ring read,
// squaring, sum update, products, difference, and result load. The sequencer
// handles one tick at a time and is ready for the next one as soon as the
// result loads; a result that is not taken holds the sequencer in its last
// step. Ring entries are used only after they were written, so the ring
// needs no clearing pass. Configuration writes land at once and must be
// issued while no tick is in flight.
module motion_spread_alarm_window_ctl_unit #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [msawc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [msawc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // request stream
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [msawc_pkg::S_DATA_W-1:0]       i_s_tdata,  // [0] motion, [12:1] distance
    // result stream
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [msawc_pkg::M_DATA_W-1:0]       o_m_tdata   // [0] move, [1] ccw, [2] buzzer
);

    msawc_pkg::t_cmd w_cmd;
    msawc_pkg::t_sts w_sts;

    // sequence the steps of one request
    msawc_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // hold the window, sums, products and result register
    msawc_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts)
    );

endmodule

### test/msawc_result_checker.sv
// ---------------------------------------------------------------------------
// msawc_result_checker: flag predictor and scoreboard
// Tracks register writes and accepted sensor ticks, predicts the motor and
// buzzer flags of each tick, and compares them with the result stream.
// ---------------------------------------------------------------------------
module msawc_result_checker #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [msawc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [msawc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_s_tvalid,
    input  logic                                 i_s_tready,
    input  logic [msawc_pkg::S_DATA_W-1:0]       i_s_tdata,  // [0] motion, [12:1] distance
    input  logic                                 i_m_tvalid,
    input  logic                                 i_m_tready,
    input  logic [msawc_pkg::M_DATA_W-1:0]       i_m_tdata,  // [0] move, [1] ccw, [2] buzzer
    output int                                   o_errors,
    output int                                   o_pending
);

    localparam int DIST_W = msawc_pkg::DIST_W;
    localparam int SUM_W  = DIST_W + $clog2(WINDOW_DEPTH);
    localparam int SQ_W   = 2 * DIST_W + $clog2(WINDOW_DEPTH);
    // room for results waiting on the stream; the unit holds at most two
    localparam int DUE_DEPTH = 8;

    // first member is the MSB, so move lands on bit 0
    typedef struct packed {
        logic buzz;
        logic ccw;
        logic move;
    } t_flags;

    localparam string FLAG_NAME [3] = '{"window_move", "window_ccw", "buzzer"};

    logic [msawc_pkg::LEN_W-1:0] close_len;
    logic [msawc_pkg::LEN_W-1:0] open_len;
    logic [msawc_pkg::THR_W-1:0] spread_thr;
    logic                        win_open;

    logic [DIST_W-1:0] dist_ring [WINDOW_DEPTH];
    int                held;
    int                next_slot;
    logic [SUM_W-1:0]  dist_sum;
    logic [SQ_W-1:0]   dist_sq_sum;
    logic              last_motion;

    t_flags            flags_due [DUE_DEPTH];
    int                due_head;
    int                due_tail;
    int                due_count;
    t_flags            want;
    t_flags            got;

    // Advance the window by one tick and return the flags it must produce.
    function automatic t_flags predict_flags(input logic motion,
                                             input logic [DIST_W-1:0] sample);
        t_flags            f;
        logic [DIST_W-1:0] evicted;
        longint unsigned   n;
        longint unsigned   t;
        longint unsigned   spread;
        longint unsigned   bound;
        f = '0;
        if (win_open) begin
            f.move = sample > open_len;
            f.ccw  = f.move;
        end else begin
            f.move = sample > close_len;
        end
        // drop the oldest sample once the window is full
        if (held == WINDOW_DEPTH) begin
            evicted     = dist_ring[next_slot];
            dist_sum    = dist_sum - SUM_W'(evicted);
            dist_sq_sum = dist_sq_sum - SQ_W'(evicted) * SQ_W'(evicted);
        end else begin
            held++;
        end
        dist_ring[next_slot] = sample;
        dist_sum             = dist_sum + SUM_W'(sample);
        dist_sq_sum          = dist_sq_sum + SQ_W'(sample) * SQ_W'(sample);
        next_slot            = (next_slot + 1) % WINDOW_DEPTH;
        // spread test on a rising motion edge, never with fewer than two samples
        if (!last_motion && motion && held >= 2) begin
            n      = held;
            t      = spread_thr;
            spread = (n * dist_sq_sum - dist_sum * dist_sum) << msawc_pkg::THR_SQ_FRAC;
            bound  = t * t * n * (n - 1);
            f.buzz = spread > bound;
        end
        last_motion = motion;
        return f;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            close_len   = '0;
            open_len    = '0;
            spread_thr  = '0;
            win_open    = 1'b0;
            held        = 0;
            next_slot   = 0;
            dist_sum    = '0;
            dist_sq_sum = '0;
            last_motion = 1'b0;
            due_head    = 0;
            due_tail    = 0;
            due_count   = 0;
            o_errors    = 0;
            o_pending  <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    msawc_pkg::REG_CLOSE_LENGTH:
                        close_len  = i_cfg_data[msawc_pkg::LEN_W-1:0];
                    msawc_pkg::REG_OPEN_LENGTH:
                        open_len   = i_cfg_data[msawc_pkg::LEN_W-1:0];
                    msawc_pkg::REG_SPREAD_THRESHOLD:
                        spread_thr = i_cfg_data[msawc_pkg::THR_W-1:0];
                    msawc_pkg::REG_WINDOW_IS_OPEN:
                        win_open   = i_cfg_data[0];
                    default: ;
                endcase
            end
            // retire the oldest prediction before adding a new one
            if (i_m_tvalid && i_m_tready) begin
                got = t_flags'(i_m_tdata[2:0]);
                if (due_count == 0) begin
                    o_errors++;
                    $display("%0t: expected no result got %h", $time, i_m_tdata);
                end else begin
                    want      = flags_due[due_head];
                    due_head  = (due_head + 1) % DUE_DEPTH;
                    due_count--;
                    for (int b = 0; b < 3; b++) begin
                        if (got[b] !== want[b]) begin
                            o_errors++;
                            $display("%0t: %s expected %0b got %0b",
                                     $time, FLAG_NAME[b], want[b], got[b]);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (due_count == DUE_DEPTH) begin
                    o_errors++;
                    $display("%0t: expected at most %0d results waiting got %0d more",
                             $time, DUE_DEPTH, 1);
                end else begin
                    flags_due[due_tail] = predict_flags(i_s_tdata[0],
                                                        i_s_tdata[DIST_W:1]);
                    due_tail = (due_tail + 1) % DUE_DEPTH;
                    due_count++;
                end
            end
            o_pending <= due_count;
        end
    end

endmodule

### test/motion_spread_alarm_window_ctl_unit_test.sv
// ---------------------------------------------------------------------------
// motion_spread_alarm_window_ctl_unit_test: stimulus and verdict
// Drives sensor ticks and register settings into the alarm unit with random
// idling on both streams; the checker beside the unit scores every result.
// ---------------------------------------------------------------------------
module motion_spread_alarm_window_ctl_unit_test;

    localparam int WINDOW_DEPTH = 16;
    localparam int DIST_W       = msawc_pkg::DIST_W;
    localparam int LEN_W        = msawc_pkg::LEN_W;
    localparam int THR_W        = msawc_pkg::THR_W;
    localparam int CFG_DATA_W   = msawc_pkg::CFG_DATA_W;
    localparam int S_DATA_W     = msawc_pkg::S_DATA_W;
    // cycles without any handshake before the run is declared hung
    localparam int STALL_LIMIT  = 2000;
    // settle time after the last result, well above the unit's latency
    localparam int TAIL_CYCLES  = 24;
    localparam int RAND_PHASES  = 5;
    localparam int PHASE_TICKS  = 86;

    logic                                clk      = 1'b0;
    logic                                rst_n    = 1'b0;
    logic                                cfg_we   = 1'b0;
    logic [msawc_pkg::CFG_IDX_W-1:0]     cfg_idx  = msawc_pkg::REG_CLOSE_LENGTH;
    logic [CFG_DATA_W-1:0]               cfg_data = '0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [S_DATA_W-1:0]                 s_tdata  = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [msawc_pkg::M_DATA_W-1:0]      m_tdata;

    int                    fails;
    int                    due;
    int                    quiet_cycles = 0;
    // set during one phase to run both streams without any idling
    logic                  calm = 1'b0;

    motion_spread_alarm_window_ctl_unit #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    msawc_result_checker #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) flag_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (fails),
        .o_pending  (due)
    );

    always #5 clk = ~clk;

    // Result side: stall about a third of the cycles except in the calm phase.
    always @(posedge clk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 32);
    end

    // Watchdog: end the run when nothing moves on either stream for too long.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Send one sensor tick: idle at random first, then hold the request until
    // it is taken. Valid stays high on return so back-to-back requests never
    // lower and raise it in the same step.
    task automatic send_tick(input logic motion, input logic [DIST_W-1:0] sample);
        while (!calm && $urandom_range(0, 99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-DIST_W-1){1'b0}}, sample, motion};
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (due != 0);
    endtask

    // Write all four registers while the unit is idle. Bits above each
    // register's width carry junk that the unit must ignore.
    task automatic load_regs(input logic [LEN_W-1:0] close_v,
                             input logic [LEN_W-1:0] open_v,
                             input logic [THR_W-1:0] thr_v,
                             input logic             open_state);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        cfg_we   <= 1'b1;
        cfg_idx  <= msawc_pkg::REG_CLOSE_LENGTH;
        cfg_data <= {junk[CFG_DATA_W-1:LEN_W], close_v};
        @(posedge clk);
        junk = CFG_DATA_W'($urandom);
        cfg_idx  <= msawc_pkg::REG_OPEN_LENGTH;
        cfg_data <= {junk[CFG_DATA_W-1:LEN_W], open_v};
        @(posedge clk);
        cfg_idx  <= msawc_pkg::REG_SPREAD_THRESHOLD;
        cfg_data <= thr_v;
        @(posedge clk);
        junk = CFG_DATA_W'($urandom);
        cfg_idx  <= msawc_pkg::REG_WINDOW_IS_OPEN;
        cfg_data <= {junk[CFG_DATA_W-1:1], open_state};
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Pick a length register value, hitting both extremes often.
    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return LEN_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [THR_W-1:0]  thr;
        logic [DIST_W-1:0] base;
        int                span;
        logic              motion;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Closed window, zero threshold: a lone first sample on an edge must
        // stay silent, a flat window must stay silent, any spread must alarm.
        load_regs('0, '1, '0, 1'b0);
        send_tick(1'b1, DIST_W'(5));
        send_tick(1'b0, DIST_W'(5));
        send_tick(1'b1, DIST_W'(5));
        send_tick(1'b0, '0);
        send_tick(1'b1, '1);
        send_tick(1'b1, '1);

        // Open window, full-scale threshold: alternate extremes until the
        // window wraps and starts dropping its oldest samples.
        drain();
        load_regs('1, '0, '1, 1'b1);
        for (int k = 0; k < 14; k++) begin
            send_tick(k[0], k[1] ? '1 : '0);
        end

        // Closed window at the top length: the largest distance must not move.
        drain();
        load_regs('1, '1, 16'h7FFF, 1'b0);
        send_tick(1'b0, '1);
        send_tick(1'b1, '1);
        send_tick(1'b0, DIST_W'(2048));
        send_tick(1'b1, DIST_W'(1));

        // Random phases: fresh settings each time, distances drawn around a
        // base with a spread that ranges from flat to full scale.
        for (int p = 0; p < RAND_PHASES; p++) begin
            drain();
            case ($urandom_range(0, 9))
                0, 1:    thr = '0;
                2:       thr = '1;
                default: thr = THR_W'($urandom_range(0, 40000));
            endcase
            load_regs(pick_length(), pick_length(), thr, 1'($urandom));
            calm   = (p == 2);
            motion = 1'b0;
            span   = 0;
            base   = '0;
            for (int k = 0; k < PHASE_TICKS; k++) begin
                // reshape the distance spread now and then
                if (k == 0 || $urandom_range(0, 99) < 10) begin
                    case ($urandom_range(0, 3))
                        0:       span = 0;
                        1:       span = 15;
                        2:       span = 255;
                        default: span = 4095;
                    endcase
                    base = DIST_W'($urandom_range(0, 4095 - span));
                end
                // toggle motion often so rising edges are common
                if ($urandom_range(0, 99) < 35) begin
                    motion = ~motion;
                end
                send_tick(motion, base + DIST_W'($urandom_range(0, span)));
            end
        end
        calm = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fails == 0 && due == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
